// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/gdv_pkg.sv =====
// shared widths, state types and codes for the difference variance block
// no dependencies
package gdv_pkg;

  // sizes
  localparam int MAX_LEVELS     = 256;
  localparam int IDX_W          = 8;
  localparam int LEVEL_W        = $clog2(MAX_LEVELS);
  localparam int CNT_W          = LEVEL_W + 1;
  localparam int PROB_FRAC_BITS = 24;
  localparam int PROB_W         = 24;
  localparam int BIN_W          = 32;
  localparam int ACC_W          = 64;
  localparam int HALF_W         = ACC_W / 2;
  localparam int SQ_W           = 2 * ACC_W;
  localparam int OUT_W          = 56;
  localparam int KK_W           = 2 * LEVEL_W;
  localparam int P1_W           = BIN_W + LEVEL_W;
  localparam int P2_W           = BIN_W + KK_W;

  // level count limit and reset value
  localparam logic [CNT_W-1:0] LEVEL_MAX = CNT_W'(MAX_LEVELS);

  // clamp limits of the signed result, at difference width
  localparam logic signed [ACC_W:0] DIF_MAX =
    {{(ACC_W - OUT_W + 2){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [ACC_W:0] DIF_MIN =
    {{(ACC_W - OUT_W + 2){1'b1}}, {(OUT_W - 1){1'b0}}};

  // partial product codes of the squarer
  localparam logic [1:0] SQ_LL = 2'd0;
  localparam logic [1:0] SQ_LH = 2'd1;
  localparam logic [1:0] SQ_HH = 2'd2;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_SWEEP,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_DIFF
  } gdv_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_ACC,
    SQ_ROUND
  } sq_state_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } sq_stat_t;

endpackage

// ===== rtl/core/gdv_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module gdv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/gdv_square.sv =====
// multi-cycle squarer: 64-bit value squared through one 32x32 multiplier,
// rounded back to the probability fraction width; uses gdv_pkg
module gdv_square (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gdv_pkg::ACC_W-1:0] value,
  output gdv_pkg::sq_stat_t         stat,
  output logic [gdv_pkg::ACC_W-1:0] result
);

  gdv_pkg::sq_state_t state_r, state_nxt;

  logic [gdv_pkg::ACC_W-1:0]  val_r;
  logic [1:0]                 step_r;
  logic [1:0]                 mul_step_r;
  logic [gdv_pkg::ACC_W-1:0]  mul_r;
  logic [gdv_pkg::SQ_W-1:0]   acc_r;
  logic [gdv_pkg::ACC_W-1:0]  result_r;
  logic                       done_r;
  logic                       ovf_r;

  logic [gdv_pkg::HALF_W-1:0] op_a;
  logic [gdv_pkg::HALF_W-1:0] op_b;
  logic [gdv_pkg::SQ_W-1:0]   term;
  logic [gdv_pkg::SQ_W-1:0]   rnd;
  logic                       rnd_ovf;

  // operand select: lo*lo, lo*hi, hi*hi
  always_comb begin
    op_a = (step_r == gdv_pkg::SQ_HH) ? val_r[gdv_pkg::ACC_W-1:gdv_pkg::HALF_W]
                                      : val_r[gdv_pkg::HALF_W-1:0];
    op_b = (step_r == gdv_pkg::SQ_LL) ? val_r[gdv_pkg::HALF_W-1:0]
                                      : val_r[gdv_pkg::ACC_W-1:gdv_pkg::HALF_W];
  end

  // align the registered partial product, cross term counted twice
  always_comb begin
    case (mul_step_r)
      gdv_pkg::SQ_LL: term = {{gdv_pkg::ACC_W{1'b0}}, mul_r};
      gdv_pkg::SQ_LH: term = {{(gdv_pkg::HALF_W - 1){1'b0}}, mul_r,
                              {(gdv_pkg::HALF_W + 1){1'b0}}};
      default:        term = {mul_r, {gdv_pkg::ACC_W{1'b0}}};
    endcase
  end

  // round to nearest, ties up, and detect overflow of 64 bits
  always_comb begin
    rnd = acc_r + (gdv_pkg::SQ_W'(1) << (gdv_pkg::PROB_FRAC_BITS - 1));
    rnd_ovf = |rnd[gdv_pkg::SQ_W-1:gdv_pkg::ACC_W+gdv_pkg::PROB_FRAC_BITS];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdv_pkg::SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdv_pkg::SQ_IDLE:  if (start) state_nxt = gdv_pkg::SQ_MUL;
      gdv_pkg::SQ_MUL:   if (step_r == gdv_pkg::SQ_HH) state_nxt = gdv_pkg::SQ_ACC;
      gdv_pkg::SQ_ACC:   state_nxt = gdv_pkg::SQ_ROUND;
      gdv_pkg::SQ_ROUND: state_nxt = gdv_pkg::SQ_IDLE;
      default:           state_nxt = gdv_pkg::SQ_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      gdv_pkg::SQ_IDLE: begin
        if (start) begin
          val_r  <= value;
          acc_r  <= '0;
          step_r <= gdv_pkg::SQ_LL;
        end
      end
      gdv_pkg::SQ_MUL: begin
        mul_r      <= gdv_pkg::ACC_W'(op_a * op_b);
        mul_step_r <= step_r;
        step_r     <= step_r + 2'd1;
        if (step_r != gdv_pkg::SQ_LL) begin
          acc_r <= acc_r + term;
        end
      end
      gdv_pkg::SQ_ACC: begin
        acc_r <= acc_r + term;
      end
      gdv_pkg::SQ_ROUND: begin
        result_r <= rnd_ovf ? '1
                  : rnd[gdv_pkg::ACC_W+gdv_pkg::PROB_FRAC_BITS-1:gdv_pkg::PROB_FRAC_BITS];
        ovf_r    <= rnd_ovf;
      end
      default: ;
    endcase
  end

  // one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (state_r == gdv_pkg::SQ_ROUND);
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign result    = result_r;

endmodule

// ===== rtl/core/glcm_difference_variance.sv =====
// top level: difference histogram of a co-occurrence matrix and its variance
// uses gdv_pkg, gdv_ram, gdv_square
//
// Matrix entries are taken one per cycle while the input is open; each adds
// its Q0.24 probability into a 256 x 32 bin histogram ram at |row - col| by
// read, add and write back, with the previous write forwarded when two close
// entries hit the same bin. Entries whose row or column is not below the level
// count are dropped. After the last entry the input stays closed while the
// block finishes the last write, makes one pass over the bins at one ram read
// per cycle with a three-stage multiply and accumulate, squares the weighted
// sum through a shared 32x32 multiplier and forms and clamps the difference.
// The histogram is empty after reset and after every result without a clearing
// pass: per-bin valid bits are dropped at once. The result sits in an output
// register, so the next matrix streams in while it waits to be taken.
module glcm_difference_variance (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gdv_pkg::IDX_W-1:0]         in_row_index,
  input  logic [gdv_pkg::IDX_W-1:0]         in_col_index,
  input  logic [gdv_pkg::PROB_W-1:0]        in_prob_value,
  input  logic                              in_last_entry,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [gdv_pkg::OUT_W-1:0]  out_diff_variance,
  output logic                              out_overflowed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gdv_pkg::CNT_W-1:0]         cfg_level_count
);

  gdv_pkg::gdv_state_t state_r, state_nxt;

  logic [gdv_pkg::CNT_W-1:0]   level_r;
  logic [gdv_pkg::CNT_W-1:0]   lv;
  logic                        in_fire;
  logic                        in_range;
  logic [gdv_pkg::LEVEL_W-1:0] in_diff;

  // update stage
  logic                        st2_v_r;
  logic                        st2_en_r;
  logic [gdv_pkg::LEVEL_W-1:0] st2_addr_r;
  logic [gdv_pkg::PROB_W-1:0]  st2_prob_r;
  logic                        fwd_v_r;
  logic [gdv_pkg::LEVEL_W-1:0] fwd_addr_r;
  logic [gdv_pkg::BIN_W-1:0]   fwd_data_r;
  logic [gdv_pkg::BIN_W-1:0]   old_bin;
  logic [gdv_pkg::BIN_W:0]     bin_sum;
  logic [gdv_pkg::BIN_W-1:0]   new_bin;
  logic                        wr_en;
  logic [gdv_pkg::MAX_LEVELS-1:0] valid_r;
  logic                        sat_seen_r;

  // ram ports
  logic [gdv_pkg::LEVEL_W-1:0] rd_addr;
  logic [gdv_pkg::BIN_W-1:0]   rd_data;

  // sweep
  logic [gdv_pkg::CNT_W-1:0]   cnt_r;
  logic [gdv_pkg::KK_W-1:0]    kk_r;
  logic                        issue;
  logic                        rd_v_r;
  logic [gdv_pkg::LEVEL_W-1:0] k_d_r;
  logic [gdv_pkg::KK_W-1:0]    kk_d_r;
  logic [gdv_pkg::BIN_W-1:0]   sweep_bin;
  logic                        mul_v_r;
  logic [gdv_pkg::P1_W-1:0]    p1_r;
  logic [gdv_pkg::P2_W-1:0]    p2_r;
  logic [gdv_pkg::ACC_W-1:0]   acc1_r;
  logic [gdv_pkg::ACC_W-1:0]   acc2_r;
  logic [gdv_pkg::ACC_W:0]     sum1;
  logic [gdv_pkg::ACC_W:0]     sum2;
  logic                        acc_ovf_r;
  logic                        sweep_done;

  // squaring and result
  gdv_pkg::sq_stat_t           sq_stat;
  logic [gdv_pkg::ACC_W-1:0]   sq_result;
  logic [gdv_pkg::ACC_W-1:0]   sq_r;
  logic                        ovf_r;
  logic signed [gdv_pkg::ACC_W:0] dif;
  logic                        dif_hi;
  logic                        dif_lo;
  logic [gdv_pkg::OUT_W-1:0]   res;
  logic                        out_load;
  logic                        out_valid_r;
  logic [gdv_pkg::OUT_W-1:0]   out_diff_r;
  logic                        out_ovf_r;

  // configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= gdv_pkg::LEVEL_MAX;
    end else if (cfg_valid) begin
      level_r <= cfg_level_count;
    end
  end

  assign lv = (level_r > gdv_pkg::LEVEL_MAX) ? gdv_pkg::LEVEL_MAX : level_r;

  // input word decode
  assign in_ready = (state_r == gdv_pkg::ST_RUN);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    in_range = (gdv_pkg::CNT_W'(in_row_index) < lv) && (gdv_pkg::CNT_W'(in_col_index) < lv);
    in_diff  = (in_row_index > in_col_index)
             ? gdv_pkg::LEVEL_W'(in_row_index - in_col_index)
             : gdv_pkg::LEVEL_W'(in_col_index - in_row_index);
  end

  // read stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st2_v_r <= 1'b0;
    end else begin
      st2_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st2_en_r   <= in_range;
      st2_addr_r <= in_diff;
      st2_prob_r <= in_prob_value;
    end
  end

  assign rd_addr = (state_r == gdv_pkg::ST_SWEEP) ? cnt_r[gdv_pkg::LEVEL_W-1:0] : in_diff;

  // bin update with forwarding of the previous write
  always_comb begin
    if (fwd_v_r && (fwd_addr_r == st2_addr_r)) begin
      old_bin = fwd_data_r;
    end else if (valid_r[st2_addr_r]) begin
      old_bin = rd_data;
    end else begin
      old_bin = '0;
    end
    bin_sum = {1'b0, old_bin} + (gdv_pkg::BIN_W + 1)'(st2_prob_r);
    new_bin = bin_sum[gdv_pkg::BIN_W] ? '1 : bin_sum[gdv_pkg::BIN_W-1:0];
    wr_en   = st2_v_r && st2_en_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= st2_addr_r;
    fwd_data_r <= new_bin;
  end

  // bin valid bits and sticky bin saturation, dropped after each sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      sat_seen_r <= 1'b0;
    end else if (sweep_done) begin
      valid_r    <= '0;
      sat_seen_r <= 1'b0;
    end else if (wr_en) begin
      valid_r[st2_addr_r] <= 1'b1;
      if (bin_sum[gdv_pkg::BIN_W]) begin
        sat_seen_r <= 1'b1;
      end
    end
  end

  // histogram memory
  gdv_ram #(
    .WIDTH (gdv_pkg::BIN_W),
    .DEPTH (gdv_pkg::MAX_LEVELS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (st2_addr_r),
    .wr_data (new_bin),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sweep: issue reads, multiply by k and k*k, accumulate
  assign issue      = (state_r == gdv_pkg::ST_SWEEP) && (cnt_r < lv);
  assign sweep_bin  = valid_r[k_d_r] ? rd_data : '0;
  assign sweep_done = (state_r == gdv_pkg::ST_SWEEP) && !issue && !rd_v_r && !mul_v_r;

  always_comb begin
    sum1 = {1'b0, acc1_r} + (gdv_pkg::ACC_W + 1)'(p1_r);
    sum2 = {1'b0, acc2_r} + (gdv_pkg::ACC_W + 1)'(p2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    k_d_r  <= cnt_r[gdv_pkg::LEVEL_W-1:0];
    kk_d_r <= kk_r;
    p1_r   <= gdv_pkg::P1_W'(k_d_r * sweep_bin);
    p2_r   <= gdv_pkg::P2_W'(kk_d_r * sweep_bin);
    if (state_r == gdv_pkg::ST_DRAIN) begin
      cnt_r     <= '0;
      kk_r      <= '0;
      acc1_r    <= '0;
      acc2_r    <= '0;
      acc_ovf_r <= 1'b0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_r + gdv_pkg::CNT_W'(1);
        kk_r  <= kk_r + gdv_pkg::KK_W'({cnt_r[gdv_pkg::LEVEL_W-1:0], 1'b1});
      end
      if (mul_v_r) begin
        acc1_r <= sum1[gdv_pkg::ACC_W] ? '1 : sum1[gdv_pkg::ACC_W-1:0];
        acc2_r <= sum2[gdv_pkg::ACC_W] ? '1 : sum2[gdv_pkg::ACC_W-1:0];
        if (sum1[gdv_pkg::ACC_W] || sum2[gdv_pkg::ACC_W]) begin
          acc_ovf_r <= 1'b1;
        end
      end
    end
  end

  // square of the weighted sum
  gdv_square u_square (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == gdv_pkg::ST_SQ_GO),
    .value  (acc1_r),
    .stat   (sq_stat),
    .result (sq_result)
  );

  // overflow collection and square capture
  always_ff @(posedge clk) begin
    if (sweep_done) begin
      ovf_r <= sat_seen_r || acc_ovf_r;
    end else if ((state_r == gdv_pkg::ST_SQ_WAIT) && sq_stat.done) begin
      ovf_r <= ovf_r || sq_stat.ovf;
      sq_r  <= sq_result;
    end
  end

  // difference and clamp
  always_comb begin
    dif    = $signed({1'b0, acc2_r}) - $signed({1'b0, sq_r});
    dif_hi = dif > gdv_pkg::DIF_MAX;
    dif_lo = dif < gdv_pkg::DIF_MIN;
    if (dif_hi) begin
      res = gdv_pkg::DIF_MAX[gdv_pkg::OUT_W-1:0];
    end else if (dif_lo) begin
      res = gdv_pkg::DIF_MIN[gdv_pkg::OUT_W-1:0];
    end else begin
      res = dif[gdv_pkg::OUT_W-1:0];
    end
    out_load = (state_r == gdv_pkg::ST_DIFF) && (!out_valid_r || out_ready);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_diff_r <= res;
      out_ovf_r  <= ovf_r || dif_hi || dif_lo;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_diff_variance = $signed(out_diff_r);
  assign out_overflowed    = out_ovf_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdv_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdv_pkg::ST_RUN:     if (in_fire && in_last_entry) state_nxt = gdv_pkg::ST_DRAIN;
      gdv_pkg::ST_DRAIN:   state_nxt = gdv_pkg::ST_SWEEP;
      gdv_pkg::ST_SWEEP:   if (sweep_done) state_nxt = gdv_pkg::ST_SQ_GO;
      gdv_pkg::ST_SQ_GO:   state_nxt = gdv_pkg::ST_SQ_WAIT;
      gdv_pkg::ST_SQ_WAIT: if (sq_stat.done) state_nxt = gdv_pkg::ST_DIFF;
      gdv_pkg::ST_DIFF:    if (out_load) state_nxt = gdv_pkg::ST_RUN;
      default:             state_nxt = gdv_pkg::ST_RUN;
    endcase
  end

endmodule

// ===== rtl/core/gdv_checker.sv =====
// port-level checker for the difference variance block, bound to the top level
// uses assert_macros.svh
`include "assert_macros.svh"

module gdv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [gdv_pkg::IDX_W-1:0]         in_row_index,
  input logic [gdv_pkg::IDX_W-1:0]         in_col_index,
  input logic [gdv_pkg::PROB_W-1:0]        in_prob_value,
  input logic                              in_last_entry,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [gdv_pkg::OUT_W-1:0]  out_diff_variance,
  input logic                              out_overflowed,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [gdv_pkg::CNT_W-1:0]         cfg_level_count
);

  // a stalled result word holds
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_diff_variance) && $stable(out_overflowed), "result word changed while stalled")

  // the last entry of a matrix closes the input for the final pass
  `ASSERT_CLK(a_last_stalls, rst_n && in_valid && in_ready && in_last_entry |=> !in_ready, "input open after last entry")

  // a new result only appears after the input was closed
  `ASSERT_CLK(a_out_after_pass, $rose(out_valid) |-> !$past(in_ready), "result without final pass")

  // reset empties the output register
  `ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind glcm_difference_variance gdv_checker u_gdv_checker (.*);
